@@ design/pacull_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the primitive assembly and face cull block.
// No dependencies; imported by every module of the block.
package pacull_pkg;

    localparam int ID_BITS     = 16;
    localparam int ID_OUT_BITS = 16;
    localparam int POS_BITS    = 18;
    localparam int DIFF_BITS   = POS_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int AREA_BITS   = PROD_BITS + 1;
    localparam int TYPE_BITS   = 3;
    localparam int CULL_BITS   = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 3;
    localparam int POSN_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_PRIMITIVE_TYPE = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CULL_MODE      = 1'd1;

    localparam logic [TYPE_BITS-1:0] PRIM_TRIANGLES = 3'd0;
    localparam logic [TYPE_BITS-1:0] PRIM_TRI_STRIP = 3'd1;
    localparam logic [TYPE_BITS-1:0] PRIM_TRI_FAN   = 3'd2;
    localparam logic [TYPE_BITS-1:0] PRIM_LINES     = 3'd3;
    localparam logic [TYPE_BITS-1:0] PRIM_LINE_STRIP = 3'd4;

    localparam logic [CULL_BITS-1:0] CULL_NONE  = 2'd0;
    localparam logic [CULL_BITS-1:0] CULL_FRONT = 2'd1;
    localparam logic [CULL_BITS-1:0] CULL_BACK  = 2'd2;

    localparam logic KIND_TRIANGLE = 1'b0;
    localparam logic KIND_LINE     = 1'b1;

    localparam logic MODE_VERTEX  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    localparam int S_TDATA_BITS = 56;
    localparam int M_TDATA_BITS = 48;

    typedef struct packed {
        logic [ID_BITS-1:0]         id;
        logic signed [POS_BITS-1:0] x;
        logic signed [POS_BITS-1:0] y;
        logic                       ok;
    } vertex_t;

    typedef struct packed {
        logic    mode;
        vertex_t vtx;
    } item_t;

    typedef struct packed {
        logic                        valid;
        logic                        kind;
        logic [ID_OUT_BITS-1:0]      first_id;
        logic [ID_OUT_BITS-1:0]      second_id;
        logic [ID_OUT_BITS-1:0]      third_id;
        logic signed [PROD_BITS-1:0] p1;
        logic signed [PROD_BITS-1:0] p2;
    } prod_t;

endpackage

@@ design/pacull_assembler.sv @@
`timescale 1ns / 1ps
// Vertex grouping: held vertices, run position, strip parity and the two
// area products, registered into the product stage. Depends on pacull_pkg.
module pacull_assembler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  pacull_pkg::item_t               in_item,
    input  logic [pacull_pkg::TYPE_BITS-1:0] prim_type,
    input  logic                            clear_run,
    input  logic                            prod_ready,
    output pacull_pkg::prod_t               prod
);
    import pacull_pkg::*;

    vertex_t held0_reg, held0_next;
    vertex_t held1_reg, held1_next;
    logic [POSN_BITS-1:0] pos_reg, pos_next;
    logic parity_reg, parity_next;
    prod_t prod_reg, prod_next;

    logic fire;
    logic restart;
    vertex_t cur, va, vb;
    logic tri_cand, line_cand, tri_ok, line_ok, emit;
    logic signed [DIFF_BITS-1:0] dx_ba, dy_ba, dx_ca, dy_ca;

    always_comb begin
        fire    = in_valid && prod_ready;
        restart = (in_item.mode == MODE_RESTART);
        cur     = in_item.vtx;

        if (prim_type == PRIM_TRI_STRIP && parity_reg) begin
            va = held1_reg;
            vb = held0_reg;
        end else begin
            va = held0_reg;
            vb = held1_reg;
        end

        tri_cand  = (prim_type == PRIM_TRIANGLES || prim_type == PRIM_TRI_STRIP ||
                     prim_type == PRIM_TRI_FAN) && pos_reg == 2'd2;
        line_cand = (prim_type == PRIM_LINES && pos_reg == 2'd1) ||
                    (prim_type == PRIM_LINE_STRIP && pos_reg != 2'd0);
        tri_ok    = va.ok && vb.ok && cur.ok;
        line_ok   = held0_reg.ok && cur.ok;
        emit      = (tri_cand && tri_ok) || (line_cand && line_ok);

        dx_ba = $signed({vb.x[POS_BITS-1], vb.x}) - $signed({va.x[POS_BITS-1], va.x});
        dy_ba = $signed({vb.y[POS_BITS-1], vb.y}) - $signed({va.y[POS_BITS-1], va.y});
        dx_ca = $signed({cur.x[POS_BITS-1], cur.x}) - $signed({va.x[POS_BITS-1], va.x});
        dy_ca = $signed({cur.y[POS_BITS-1], cur.y}) - $signed({va.y[POS_BITS-1], va.y});

        held0_next  = held0_reg;
        held1_next  = held1_reg;
        pos_next    = pos_reg;
        parity_next = parity_reg;

        if (fire && restart) begin
            pos_next    = '0;
            parity_next = 1'b0;
        end else if (fire) begin
            case (prim_type)
                PRIM_TRIANGLES: begin
                    if (pos_reg == 2'd0) begin
                        held0_next = cur;
                        pos_next   = 2'd1;
                    end else if (pos_reg == 2'd1) begin
                        held1_next = cur;
                        pos_next   = 2'd2;
                    end else begin
                        pos_next = 2'd0;
                    end
                end
                PRIM_TRI_STRIP: begin
                    if (pos_reg == 2'd0) begin
                        held0_next = cur;
                        pos_next   = 2'd1;
                    end else if (pos_reg == 2'd1) begin
                        held1_next = cur;
                        pos_next   = 2'd2;
                    end else begin
                        parity_next = !parity_reg;
                        held0_next  = held1_reg;
                        held1_next  = cur;
                    end
                end
                PRIM_TRI_FAN: begin
                    if (pos_reg == 2'd0) begin
                        held0_next = cur;
                        pos_next   = 2'd1;
                    end else begin
                        held1_next = cur;
                        pos_next   = 2'd2;
                    end
                end
                PRIM_LINES: begin
                    if (pos_reg == 2'd0) begin
                        held0_next = cur;
                        pos_next   = 2'd1;
                    end else begin
                        pos_next = 2'd0;
                    end
                end
                PRIM_LINE_STRIP: begin
                    held0_next = cur;
                    pos_next   = 2'd1;
                end
                default: begin
                end
            endcase
        end

        if (clear_run) begin
            pos_next    = '0;
            parity_next = 1'b0;
        end

        prod_next = prod_reg;
        if (prod_ready) begin
            prod_next.valid = fire && !restart && emit;
            if (line_cand) begin
                prod_next.kind      = KIND_LINE;
                prod_next.first_id  = ID_OUT_BITS'(held0_reg.id);
                prod_next.second_id = ID_OUT_BITS'(cur.id);
                prod_next.third_id  = '0;
            end else begin
                prod_next.kind      = KIND_TRIANGLE;
                prod_next.first_id  = ID_OUT_BITS'(va.id);
                prod_next.second_id = ID_OUT_BITS'(vb.id);
                prod_next.third_id  = ID_OUT_BITS'(cur.id);
            end
            prod_next.p1 = dx_ba * dy_ca;
            prod_next.p2 = dy_ba * dx_ca;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            parity_reg     <= 1'b0;
            prod_reg.valid <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            parity_reg     <= parity_next;
            prod_reg.valid <= prod_next.valid;
        end
        held0_reg          <= held0_next;
        held1_reg          <= held1_next;
        prod_reg.kind      <= prod_next.kind;
        prod_reg.first_id  <= prod_next.first_id;
        prod_reg.second_id <= prod_next.second_id;
        prod_reg.third_id  <= prod_next.third_id;
        prod_reg.p1        <= prod_next.p1;
        prod_reg.p2        <= prod_next.p2;
    end

    assign prod = prod_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("run position out of range");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && restart |=> pos_reg == 2'd0 && !parity_reg)
        else $error("restart did not clear the run");

    a_parity_strip_only: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire && !clear_run |=> $stable(parity_reg) && $stable(pos_reg))
        else $error("run state moved without a beat");

    a_no_emit_on_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && restart |=> !prod_reg.valid)
        else $error("restart produced a primitive");

endmodule

@@ design/pacull_face_test.sv @@
`timescale 1ns / 1ps
// Signed area from the registered products, zero-area and facing drop, and
// the result register on the master side. Depends on pacull_pkg.
module pacull_face_test (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pacull_pkg::prod_t                     prod,
    input  logic [pacull_pkg::CULL_BITS-1:0]      cull_mode,
    output logic                                  prod_ready,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [pacull_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                  m_tuser
);
    import pacull_pkg::*;

    logic signed [AREA_BITS-1:0] area;
    logic area_zero, area_neg, area_pos, keep;
    logic valid_reg, valid_next;
    logic kind_reg;
    logic [M_TDATA_BITS-1:0] data_reg;

    always_comb begin
        area = $signed({prod.p1[PROD_BITS-1], prod.p1}) -
               $signed({prod.p2[PROD_BITS-1], prod.p2});
        area_zero = (area == '0);
        area_neg  = area[AREA_BITS-1];
        area_pos  = !area_neg && !area_zero;
        if (prod.kind == KIND_LINE) begin
            keep = 1'b1;
        end else begin
            keep = !area_zero &&
                   !(cull_mode == CULL_FRONT && area_pos) &&
                   !(cull_mode == CULL_BACK && area_neg);
        end
        prod_ready = !valid_reg || m_tready;
        valid_next = prod_ready ? (prod.valid && keep) : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (prod_ready && prod.valid && keep) begin
            kind_reg <= prod.kind;
            data_reg <= {prod.third_id, prod.second_id, prod.first_id};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = data_reg;

endmodule

@@ design/primitive_assembly_with_face_cull.sv @@
`timescale 1ns / 1ps
// Primitive assembly with face cull: groups a vertex stream into triangles
// or lines and drops primitives with a failed vertex and degenerate or culled triangles.
// Depends on pacull_pkg, pacull_assembler and pacull_face_test.
//
// Slave side: one beat per vertex; s_tuser high marks a restart beat that
// begins a new run and yields nothing. Master side: one beat per emitted
// primitive, m_tuser gives its kind, m_tdata its vertex identifiers.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 the
// primitive type, 1 the cull mode). The user must write only while no beat is
// in flight; the block does not enforce it. Writing the type begins a new run.
// A closing vertex accepted into the input register passes through the product
// register, then the result register, to the master side. Throughput: one
// vertex per cycle while the master side does not stall; the two area products
// are formed in parallel in one stage, so nothing iterates.
// Reset (aresetn low at a clock edge) empties all stages, clears both
// registers and the run position. When the receiver stalls, the result is
// held and the product stage freezes; s_tready falls once the input
// register holds a beat.
module primitive_assembly_with_face_cull (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // vertex_id[15:0], pos_x[33:16], pos_y[51:34], projected_ok[52], zero
    input  logic [pacull_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // mode[0]
    input  logic                                    s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // first_vertex[15:0], second_vertex[31:16], third_vertex[47:32]
    output logic [pacull_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // kind[0]
    output logic                                    m_tuser,
    input  logic                                    cfg_wr_en,
    input  logic [pacull_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [pacull_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import pacull_pkg::*;

    logic in_valid_reg, in_valid_next;
    item_t in_item_reg;
    item_t s_item;
    logic [TYPE_BITS-1:0] prim_type_reg, prim_type_next;
    logic [CULL_BITS-1:0] cull_mode_reg, cull_mode_next;
    logic clear_run;
    logic prod_ready;
    prod_t prod;

    always_comb begin
        s_item.mode   = s_tuser;
        s_item.vtx.id = ID_BITS'(s_tdata[ID_OUT_BITS-1:0]);
        s_item.vtx.x  = s_tdata[ID_OUT_BITS +: POS_BITS];
        s_item.vtx.y  = s_tdata[ID_OUT_BITS + POS_BITS +: POS_BITS];
        s_item.vtx.ok = s_tdata[ID_OUT_BITS + 2 * POS_BITS];

        s_tready      = !in_valid_reg || prod_ready;
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;

        prim_type_next = prim_type_reg;
        cull_mode_next = cull_mode_reg;
        clear_run      = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PRIMITIVE_TYPE: begin
                    prim_type_next = cfg_wdata;
                    clear_run      = 1'b1;
                end
                REG_CULL_MODE: begin
                    cull_mode_next = cfg_wdata[CULL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            prim_type_reg <= PRIM_TRIANGLES;
            cull_mode_reg <= CULL_NONE;
        end else begin
            in_valid_reg  <= in_valid_next;
            prim_type_reg <= prim_type_next;
            cull_mode_reg <= cull_mode_next;
        end
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    pacull_assembler u_assembler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_valid_reg),
        .in_item    (in_item_reg),
        .prim_type  (prim_type_reg),
        .clear_run  (clear_run),
        .prod_ready (prod_ready),
        .prod       (prod)
    );

    pacull_face_test u_face_test (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .prod       (prod),
        .cull_mode  (cull_mode_reg),
        .prod_ready (prod_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ bench/assembly_checker.sv @@
`timescale 1ns / 1ps
// Checker for primitive_assembly_with_face_cull: tracks register writes, predicts
// the primitive beats from accepted vertex beats and compares them on the master side.
// Depends on pacull_pkg only.
module assembly_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [pacull_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  logic                                 s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [pacull_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 cfg_wr_en,
    input  logic [pacull_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [pacull_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output int                                   fail_count,
    output int                                   outstanding
);
    import pacull_pkg::*;

    typedef struct packed {
        logic                   kind;
        logic [ID_OUT_BITS-1:0] first;
        logic [ID_OUT_BITS-1:0] second;
        logic [ID_OUT_BITS-1:0] third;
    } primitive_t;

    logic [TYPE_BITS-1:0] prim_type;
    logic [CULL_BITS-1:0] cull;
    vertex_t              held [2];
    logic [POSN_BITS-1:0] run_pos;
    logic                 strip_odd;
    primitive_t           expected_prims [$];
    int                   errors;

    // a and b are held slots, c is the closing vertex
    function automatic bit face_test(int a, int b, vertex_t c, output primitive_t p);
        longint ax, ay, bx, by, cx, cy, area;
        p = '0;
        if (!held[a].ok || !held[b].ok || !c.ok) return 1'b0;
        ax = $signed(held[a].x);
        ay = $signed(held[a].y);
        bx = $signed(held[b].x);
        by = $signed(held[b].y);
        cx = $signed(c.x);
        cy = $signed(c.y);
        area = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        if (area == 0) return 1'b0;
        if (cull == CULL_FRONT && area > 0) return 1'b0;
        if (cull == CULL_BACK && area < 0) return 1'b0;
        p.kind   = KIND_TRIANGLE;
        p.first  = held[a].id[ID_OUT_BITS-1:0];
        p.second = held[b].id[ID_OUT_BITS-1:0];
        p.third  = c.id[ID_OUT_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic bit line_test(vertex_t c, output primitive_t p);
        p = '0;
        if (!held[0].ok || !c.ok) return 1'b0;
        p.kind   = KIND_LINE;
        p.first  = held[0].id[ID_OUT_BITS-1:0];
        p.second = c.id[ID_OUT_BITS-1:0];
        return 1'b1;
    endfunction

    function automatic bit assemble(vertex_t v, output primitive_t p);
        bit emit;
        emit = 1'b0;
        p = '0;
        case (prim_type)
            PRIM_TRIANGLES: begin
                if (run_pos < 2) begin
                    held[run_pos[0]] = v;
                    run_pos++;
                end else begin
                    emit = face_test(0, 1, v, p);
                    run_pos = '0;
                end
            end
            PRIM_TRI_STRIP: begin
                if (run_pos < 2) begin
                    held[run_pos[0]] = v;
                    run_pos++;
                end else begin
                    emit = strip_odd ? face_test(1, 0, v, p) : face_test(0, 1, v, p);
                    strip_odd = ~strip_odd;
                    held[0] = held[1];
                    held[1] = v;
                end
            end
            PRIM_TRI_FAN: begin
                if (run_pos < 2) begin
                    held[run_pos[0]] = v;
                    run_pos++;
                end else begin
                    emit = face_test(0, 1, v, p);
                    held[1] = v;
                end
            end
            PRIM_LINES: begin
                if (run_pos == 0) begin
                    held[0] = v;
                    run_pos = 1;
                end else begin
                    emit = line_test(v, p);
                    run_pos = '0;
                end
            end
            PRIM_LINE_STRIP: begin
                if (run_pos != 0) emit = line_test(v, p);
                held[0] = v;
                run_pos = 1;
            end
            default: ;
        endcase
        return emit;
    endfunction

    function automatic void report(string field, int want, int got);
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin
        primitive_t got, want, p;
        vertex_t    v;
        if (!aresetn) begin
            prim_type = PRIM_TRIANGLES;
            cull      = CULL_NONE;
            held[0]   = '0;
            held[1]   = '0;
            run_pos   = '0;
            strip_odd = 1'b0;
            errors    = 0;
            expected_prims.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_PRIMITIVE_TYPE) begin
                    prim_type = cfg_wdata[TYPE_BITS-1:0];
                    run_pos   = '0;
                    strip_odd = 1'b0;
                end else if (cfg_index == REG_CULL_MODE) begin
                    cull = cfg_wdata[CULL_BITS-1:0];
                end
            end
            // compare before predicting so a stray beat never consumes a fresh entry
            if (m_tvalid && m_tready) begin
                got.kind   = m_tuser;
                got.first  = m_tdata[15:0];
                got.second = m_tdata[31:16];
                got.third  = m_tdata[47:32];
                if (expected_prims.size() == 0) begin
                    errors++;
                    $display("%0t: expected no beat, actual kind %0d ids %0d %0d %0d",
                             $time, got.kind, got.first, got.second, got.third);
                end else begin
                    want = expected_prims.pop_front();
                    if (got.kind !== want.kind) report("kind", want.kind, got.kind);
                    if (got.first !== want.first) report("first_vertex", want.first, got.first);
                    if (got.second !== want.second)
                        report("second_vertex", want.second, got.second);
                    if (got.third !== want.third) report("third_vertex", want.third, got.third);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == MODE_RESTART) begin
                    run_pos   = '0;
                    strip_odd = 1'b0;
                end else begin
                    v.id = s_tdata[15:0];
                    v.x  = s_tdata[33:16];
                    v.y  = s_tdata[51:34];
                    v.ok = s_tdata[52];
                    if (assemble(v, p)) expected_prims.push_back(p);
                end
            end
        end
        outstanding <= expected_prims.size();
        fail_count  <= errors;
    end

endmodule

@@ bench/primitive_assembly_with_face_cull_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for primitive_assembly_with_face_cull: drives vertex beats, register
// writes and master-side stalls; assembly_checker does the prediction and comparison.
// Depends on pacull_pkg, the block and assembly_checker.
module primitive_assembly_with_face_cull_tb;
    import pacull_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 60;

    localparam logic [POS_BITS-1:0]  POS_MAX        = 18'h1ffff;
    localparam logic [POS_BITS-1:0]  POS_MIN        = 18'h20000;
    localparam logic [TYPE_BITS-1:0] PRIM_UNDEFINED = 3'd7;
    localparam logic [CULL_BITS-1:0] CULL_UNDEFINED = 2'd3;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_BITS-1:0]  s_tdata   = '0;
    logic                     s_tuser   = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]  m_tdata;
    logic                     m_tuser;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    int                       fail_count;
    int                       outstanding;
    int                       cycle_count = 0;
    bit                       tx_busy = 1'b1;
    logic [TYPE_BITS-1:0]     cur_type = PRIM_TRIANGLES;

    primitive_assembly_with_face_cull dut (.*);

    assembly_checker checker_i (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // master side: random stalls, stretches without stalls, and long hold-offs
    initial begin : receiver
        int beats;
        int stall;
        bit busy;
        beats = 0;
        busy  = 1'b1;
        @(posedge aclk iff aresetn);
        forever begin
            if (beats == 40 || beats == 300 || beats == 600) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if (beats % 50 == 0) busy = ($urandom_range(0, 3) != 0);
            stall = busy ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            beats++;
        end
    end

    task automatic send_beat(input logic mode, input logic [ID_BITS-1:0] id,
                             input logic [POS_BITS-1:0] x, input logic [POS_BITS-1:0] y,
                             input logic ok);
        int gap;
        gap = tx_busy ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_BITS - ID_BITS - 2 * POS_BITS - 1){1'b0}}, ok, y, x, id};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_vertex(input logic [ID_BITS-1:0] id, input logic [POS_BITS-1:0] x,
                               input logic [POS_BITS-1:0] y, input logic ok);
        send_beat(MODE_VERTEX, id, x, y, ok);
    endtask

    // hold the sender until every predicted beat has arrived and the pipe is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_PRIMITIVE_TYPE) cur_type = val[TYPE_BITS-1:0];
    endtask

    function automatic logic [POS_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       pick_coord = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
            1, 2, 3: pick_coord = POS_BITS'($urandom_range(0, 6) - 3);
            default: pick_coord = POS_BITS'($urandom);
        endcase
    endfunction

    task automatic send_random_item();
        if ($urandom_range(0, 19) == 0)
            send_beat(MODE_RESTART, ID_BITS'($urandom), pick_coord(), pick_coord(),
                      1'($urandom));
        else
            send_vertex(ID_BITS'($urandom), pick_coord(), pick_coord(),
                        $urandom_range(0, 15) != 0);
    endtask

    initial begin : stimulus
        int phase_len;
        int counted;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(REG_PRIMITIVE_TYPE, PRIM_TRIANGLES);
        write_reg(REG_CULL_MODE, CFG_DATA_BITS'(CULL_NONE));
        send_vertex(16'h0000, POS_MIN, POS_MIN, 1'b1);
        send_vertex(16'hffff, POS_MAX, POS_MIN, 1'b1);
        send_vertex(16'h0001, POS_MIN, POS_MAX, 1'b1);
        // drop: collinear
        send_vertex(16'h0002, 18'd0, 18'd0, 1'b1);
        send_vertex(16'h0003, 18'd16, 18'd16, 1'b1);
        send_vertex(16'h0004, 18'd32, 18'd32, 1'b1);
        // restart in the middle of a triangle
        send_vertex(16'h0008, 18'd5, 18'd7, 1'b1);
        send_vertex(16'h0009, 18'd9, 18'd3, 1'b1);
        send_beat(MODE_RESTART, 16'h5a5a, POS_MAX, POS_MIN, 1'b0);
        send_vertex(16'h000a, 18'd0, 18'd0, 1'b1);
        send_vertex(16'h000b, 18'd0, 18'd100, 1'b1);
        send_vertex(16'h000c, 18'd100, 18'd0, 1'b1);

        write_reg(REG_CULL_MODE, CFG_DATA_BITS'(CULL_FRONT));
        send_vertex(16'h0010, 18'd0, 18'd0, 1'b1);
        send_vertex(16'h0011, 18'd100, 18'd0, 1'b1);
        send_vertex(16'h0012, 18'd0, 18'd100, 1'b1);

        write_reg(REG_PRIMITIVE_TYPE, PRIM_TRI_STRIP);
        write_reg(REG_CULL_MODE, CFG_DATA_BITS'(CULL_BACK));
        send_vertex(16'h0020, 18'd0, 18'd0, 1'b1);
        send_vertex(16'h0021, 18'd100, 18'd0, 1'b1);
        send_vertex(16'h0022, 18'd0, 18'd100, 1'b1);
        send_vertex(16'h0023, 18'd100, 18'd100, 1'b1);

        write_reg(REG_PRIMITIVE_TYPE, PRIM_TRI_FAN);
        write_reg(REG_CULL_MODE, CFG_DATA_BITS'(CULL_UNDEFINED));
        send_vertex(16'h0030, 18'd0, 18'd0, 1'b1);
        send_vertex(16'h0031, 18'd100, 18'd0, 1'b1);
        send_vertex(16'h0032, 18'd100, 18'd100, 1'b1);
        send_vertex(16'h0033, 18'd0, 18'd100, 1'b1);

        write_reg(REG_PRIMITIVE_TYPE, PRIM_LINES);
        send_vertex(16'h0040, POS_MIN, POS_MAX, 1'b1);
        send_vertex(16'h0041, POS_MAX, POS_MIN, 1'b1);

        write_reg(REG_PRIMITIVE_TYPE, PRIM_LINE_STRIP);
        send_vertex(16'h0050, 18'd1, 18'd2, 1'b1);
        send_vertex(16'h0051, 18'd3, 18'd4, 1'b1);
        send_vertex(16'h0052, 18'd5, 18'd6, 1'b0);

        write_reg(REG_PRIMITIVE_TYPE, PRIM_UNDEFINED);
        send_vertex(16'h0060, 18'd7, 18'd8, 1'b1);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 7) == 0)
                    write_reg(REG_PRIMITIVE_TYPE,
                              CFG_DATA_BITS'($urandom_range(PRIM_LINE_STRIP + 1,
                                                            PRIM_UNDEFINED)));
                else
                    write_reg(REG_PRIMITIVE_TYPE,
                              CFG_DATA_BITS'($urandom_range(PRIM_TRIANGLES,
                                                            PRIM_LINE_STRIP)));
            end
            write_reg(REG_CULL_MODE, CFG_DATA_BITS'($urandom_range(CULL_NONE, CULL_UNDEFINED)));
            tx_busy = ($urandom_range(0, 2) != 0);
            phase_len = (cur_type > PRIM_LINE_STRIP) ? 6 : $urandom_range(20, 120);
            repeat (phase_len) send_random_item();
            if (cur_type <= PRIM_LINE_STRIP) counted += phase_len;
        end

        drain();
        if (fail_count == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
